/* hw/rtl/octnd_pkg.sv */
// ----------------------------------------------------------------------------
// Octree node pool package
// Shared constants and control types for the octree insert/lookup block.
// ----------------------------------------------------------------------------
package octnd_pkg;

   // Default number of tree levels walked per item.
   localparam int LEVELS_DEF = 32;
   // Default number of nodes in the pool, root included.
   localparam int NODE_COUNT_DEF = 65536;

   // Every node has eight children, chosen by a three-bit slot.
   localparam int FANOUT = 8;
   localparam int SLOT_W = 3;

   // Coordinate and result field widths.
   localparam int COORD_W = 32;
   localparam int LEAF_W  = 16;

   // Write control for one row of the node memory.
   typedef struct packed {
      logic              en;
      logic [FANOUT-1:0] lanes;
   } octnd_wr_ctl_type;

endpackage

/* hw/rtl/octnd_channels.sv */
// ----------------------------------------------------------------------------
// Octree channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface octnd_req_if import octnd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               action;
   logic [COORD_W-1:0] x_coord;
   logic [COORD_W-1:0] y_coord;
   logic [COORD_W-1:0] z_coord;

   modport source (output valid, output action, output x_coord, output y_coord,
                   output z_coord, input ready);
   modport sink   (input valid, input action, input x_coord, input y_coord,
                   input z_coord, output ready);
endinterface

interface octnd_rsp_if import octnd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LEAF_W-1:0] leaf_index;
   logic              found;
   logic              pool_full;

   modport source (output valid, output leaf_index, output found, output pool_full,
                   input ready);
   modport sink   (input valid, input leaf_index, input found, input pool_full,
                   output ready);
endinterface

/* hw/rtl/octnd_node_mem.sv */
// ----------------------------------------------------------------------------
// Octree node memory
// One row holds the child-base entries of eight sibling nodes. One row is
// written per cycle under a lane mask, and one row is read with registered data.
// ----------------------------------------------------------------------------
module octnd_node_mem import octnd_pkg::*; #(
   parameter int ROWS   = 8191,
   parameter int ROW_AW = 13,
   parameter int IDX_W  = 16
) (
   input  logic                          clock,
   input  octnd_wr_ctl_type              wr_ctl,
   input  logic [ROW_AW-1:0]             wr_row,
   input  logic [IDX_W-1:0]              wr_data,
   input  logic [ROW_AW-1:0]             rd_row,
   output logic [FANOUT-1:0][IDX_W-1:0]  rd_data
);

   logic [FANOUT-1:0][IDX_W-1:0] mem [ROWS];
   logic [FANOUT-1:0][IDX_W-1:0] rd_data_ff;

   // Lane-masked write port.
   always_ff @(posedge clock) begin
      if (wr_ctl.en) begin
         for (int i = 0; i < FANOUT; i++) begin
            if (wr_ctl.lanes[i]) begin
               mem[wr_row][i] <= wr_data;
            end
         end
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_row];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/octree_node_insert_lookup_unit.sv */
// ----------------------------------------------------------------------------
// Octree node insert/lookup unit
// Walks a sparse octree from the root along the Morton path of a point,
// allocating missing child groups on insert and reporting the leaf node.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  req_chan  in   valid/ready    action, x_coord, y_coord, z_coord
//  rsp_chan  out  valid/ready    leaf_index, found, pool_full
//
// One item at a time. Each level passes a row read state and then a decide
// state, plus a clear state for the new row and a link state for the parent
// when insert allocates a child group. Reset clears the root entry and the
// allocator; other node entries are written before they are read. A stalled
// result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module octree_node_insert_lookup_unit import octnd_pkg::*; #(
   parameter int LEVELS     = LEVELS_DEF,
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   octnd_req_if.sink    req_chan,
   octnd_rsp_if.source  rsp_chan
);

   localparam int NW         = $clog2(NODE_COUNT);
   localparam int NF_W       = $clog2(NODE_COUNT + 1);
   localparam int LVL_W      = $clog2(LEVELS + 1);
   localparam int ROWS       = (NODE_COUNT - 1) / FANOUT;
   localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int EXT_W      = (NW > LEAF_W) ? NW : LEAF_W;
   localparam int PRE_SHIFT  = COORD_W - LEVELS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_EVAL = 3'd2;
   localparam logic [2:0] ST_ZERO = 3'd3;
   localparam logic [2:0] ST_LINK = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic               ins_ff, ins_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic [NW-1:0]      node_ff, node_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [NW-1:0]      root_base_ff, root_base_in;
   logic [NF_W-1:0]    next_free_ff, next_free_in;
   logic [NW-1:0]      res_leaf_ff, res_leaf_in;
   logic               res_found_ff, res_found_in;
   logic               res_full_ff, res_full_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEAF_W-1:0]  rsp_leaf_ff, rsp_leaf_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_full_ff, rsp_full_in;

   logic                         req_take;
   logic [NW-1:0]                node_m1;
   logic [NW-1:0]                free_m1;
   logic [SLOT_W-1:0]            lane;
   logic [SLOT_W-1:0]            slot;
   logic [NW-1:0]                base;
   logic [NW-1:0]                free_idx;
   logic                         pool_short;
   logic [EXT_W-1:0]             leaf_ext;
   octnd_wr_ctl_type             wr_ctl;
   logic [ROW_AW-1:0]            wr_row;
   logic [NW-1:0]                wr_data;
   logic [ROW_AW-1:0]            rd_row;
   logic [FANOUT-1:0][NW-1:0]    rd_data;

   // Node memory; the root entry lives in a register of its own.
   octnd_node_mem #(
      .ROWS   (ROWS),
      .ROW_AW (ROW_AW),
      .IDX_W  (NW)
   ) u_mem (
      .clock   (clock),
      .wr_ctl  (wr_ctl),
      .wr_row  (wr_row),
      .wr_data (wr_data),
      .rd_row  (rd_row),
      .rd_data (rd_data)
   );

   // Node n >= 1 sits in row (n-1)/8, lane (n-1)%8.
   assign node_m1    = node_ff - NW'(1);
   assign free_idx   = NW'(next_free_ff);
   assign free_m1    = free_idx - NW'(1);
   assign lane       = node_m1[SLOT_W-1:0];
   assign rd_row     = ROW_AW'(node_m1 >> SLOT_W);
   assign slot       = {z_ff[COORD_W-1], y_ff[COORD_W-1], x_ff[COORD_W-1]};
   assign base       = (node_ff == '0) ? root_base_ff : rd_data[lane];
   assign pool_short = next_free_ff > NF_W'(NODE_COUNT - FANOUT);
   assign req_take   = req_chan.valid && req_chan.ready;

   // Memory writes: clear a fresh child row, then link it to its parent.
   always_comb begin
      wr_ctl.en    = 1'b0;
      wr_ctl.lanes = '0;
      wr_row       = ROW_AW'(free_m1 >> SLOT_W);
      wr_data      = '0;
      if (state_ff == ST_ZERO) begin
         wr_ctl.en    = 1'b1;
         wr_ctl.lanes = '1;
      end else if (state_ff == ST_LINK && node_ff != '0) begin
         wr_ctl.en    = 1'b1;
         wr_ctl.lanes = FANOUT'(1) << lane;
         wr_row       = rd_row;
         wr_data      = free_idx;
      end
   end

   // Walk sequencer.
   always_comb begin
      state_in     = state_ff;
      ins_in       = ins_ff;
      lvl_in       = lvl_ff;
      node_in      = node_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      root_base_in = root_base_ff;
      next_free_in = next_free_ff;
      res_leaf_in  = res_leaf_ff;
      res_found_in = res_found_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_leaf_in  = rsp_leaf_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               ins_in   = req_chan.action;
               lvl_in   = LVL_W'(LEVELS);
               node_in  = '0;
               x_in     = req_chan.x_coord << PRE_SHIFT;
               y_in     = req_chan.y_coord << PRE_SHIFT;
               z_in     = req_chan.z_coord << PRE_SHIFT;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // The row read is in flight; the bottom level ends the walk.
            if (lvl_ff == '0) begin
               res_leaf_in  = node_ff;
               res_found_in = 1'b1;
               res_full_in  = 1'b0;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (base != '0) begin
               node_in  = base + NW'(slot);
               lvl_in   = lvl_ff - LVL_W'(1);
               x_in     = x_ff << 1;
               y_in     = y_ff << 1;
               z_in     = z_ff << 1;
               state_in = ST_READ;
            end else if (!ins_ff || pool_short) begin
               // Lookup miss, or insert out of free nodes.
               res_leaf_in  = '0;
               res_found_in = 1'b0;
               res_full_in  = ins_ff;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            state_in = ST_LINK;
         end
         ST_LINK: begin
            if (node_ff == '0) begin
               root_base_in = free_idx;
            end
            next_free_in = next_free_ff + NF_W'(FANOUT);
            node_in      = free_idx + NW'(slot);
            lvl_in       = lvl_ff - LVL_W'(1);
            x_in         = x_ff << 1;
            y_in         = y_ff << 1;
            z_in         = z_ff << 1;
            state_in     = ST_READ;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_leaf_in  = leaf_ext[LEAF_W-1:0];
               rsp_found_in = res_found_ff;
               rsp_full_in  = res_full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign leaf_ext = EXT_W'(res_leaf_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         root_base_ff <= '0;
         next_free_ff <= NF_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_base_ff <= root_base_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk and result payload registers.
   always_ff @(posedge clock) begin
      ins_ff       <= ins_in;
      lvl_ff       <= lvl_in;
      node_ff      <= node_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      res_leaf_ff  <= res_leaf_in;
      res_found_ff <= res_found_in;
      res_full_ff  <= res_full_in;
      rsp_leaf_ff  <= rsp_leaf_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.leaf_index = rsp_leaf_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.pool_full  = rsp_full_ff;

   // The allocator only ever moves forward by one child group.
   a_free_step: assert property (@(posedge clock) disable iff (reset)
      (next_free_ff == $past(next_free_ff)) ||
      (next_free_ff == $past(next_free_ff) + NF_W'(FANOUT)))
      else $error("free pointer moved by other than one child group");

   // The allocator never hands out nodes beyond the pool.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NF_W'(NODE_COUNT - FANOUT + 1))
      else $error("free pointer ran past the pool");

   // A miss or a full pool always reports the null leaf.
   a_miss_leaf: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.found |-> rsp_chan.leaf_index == '0)
      else $error("leaf index set on a miss");

   // Found and pool-full never come together.
   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.found && rsp_chan.pool_full))
      else $error("found and pool_full both set");

endmodule
